>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define DTOA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define DTOA_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/dtoa_pkg.sv
// Types and constants shared by the date and time offset adder modules.
package dtoa_pkg;

    // Which quantity the shared divider is working on.
    typedef enum logic [1:0] {
        DIV_YEAR,
        DIV_MIN,
        DIV_HOUR
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_init;
        logic     div_step;
        logic     div_store;
        t_div_sel div_sel;
        logic     roll_step;
    } t_dp_cmd;

    typedef struct packed {
        logic roll_done;
    } t_dp_sts;

endpackage

>>> rtl/date_time_offset_adder_core.sv
// Top level of the date and time offset adder: controller plus datapath.
//
// Channel   Signals                           Transfer
// request   start, busy, i_start_*, i_delta_* start high while busy is low
// result    o_valid, o_end_*, o_year_*        o_valid high for one cycle
//
// A request runs three divisions and then the month roll before the result strobe.
// The shared reciprocal divider runs in turn on year mod 400, minutes by 60 and
// hours by 24, each through the init, step and store states; the month roll then
// takes one month per cycle until no month border is left to cross.
// Reset is synchronous and active low; it returns the controller to idle.
// The result is never stalled; a new request may be accepted in the strobe cycle.
module date_time_offset_adder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [13:0]        i_start_year,
    input  logic [3:0]         i_start_month,
    input  logic [4:0]         i_start_day,
    input  logic [4:0]         i_start_hour,
    input  logic [5:0]         i_start_minute,
    input  logic signed [16:0] i_delta_minutes,
    input  logic signed [10:0] i_delta_hours,
    input  logic signed [10:0] i_delta_days,
    output logic               o_valid,
    output logic [13:0]        o_end_year,
    output logic [3:0]         o_end_month,
    output logic [4:0]         o_end_day,
    output logic [4:0]         o_end_hour,
    output logic [5:0]         o_end_minute,
    output logic               o_year_out_of_range
);

    dtoa_pkg::t_dp_cmd s_cmd;
    dtoa_pkg::t_dp_sts s_sts;

    dtoa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    dtoa_datapath u_datapath (
        .i_clk               (i_clk),
        .i_cmd               (s_cmd),
        .i_start_year        (i_start_year),
        .i_start_month       (i_start_month),
        .i_start_day         (i_start_day),
        .i_start_hour        (i_start_hour),
        .i_start_minute      (i_start_minute),
        .i_delta_minutes     (i_delta_minutes),
        .i_delta_hours       (i_delta_hours),
        .i_delta_days        (i_delta_days),
        .o_end_year          (o_end_year),
        .o_end_month         (o_end_month),
        .o_end_day           (o_end_day),
        .o_end_hour          (o_end_hour),
        .o_end_minute        (o_end_minute),
        .o_year_out_of_range (o_year_out_of_range),
        .o_sts               (s_sts)
    );

endmodule

>>> rtl/dtoa_datapath.sv
// Datapath: input capture, shared reciprocal divider and the month roll unit.
module dtoa_datapath (
    input  logic               i_clk,
    input  dtoa_pkg::t_dp_cmd  i_cmd,
    input  logic [13:0]        i_start_year,
    input  logic [3:0]         i_start_month,
    input  logic [4:0]         i_start_day,
    input  logic [4:0]         i_start_hour,
    input  logic [5:0]         i_start_minute,
    input  logic signed [16:0] i_delta_minutes,
    input  logic signed [10:0] i_delta_hours,
    input  logic signed [10:0] i_delta_days,
    output logic [13:0]        o_end_year,
    output logic [3:0]         o_end_month,
    output logic [4:0]         o_end_day,
    output logic [4:0]         o_end_hour,
    output logic [5:0]         o_end_minute,
    output logic               o_year_out_of_range,
    output dtoa_pkg::t_dp_sts  o_sts
);

    // Biases make the dividends positive: 60 * 1093 and 24 * 89.
    localparam logic signed [18:0] MIN_OFFSET  = 19'sd65580;
    localparam logic signed [13:0] HOUR_OFFSET = 14'sd2136;
    localparam logic [11:0]        MIN_BIAS    = 12'd1093;
    localparam logic [11:0]        HOUR_BIAS   = 12'd89;
    localparam logic [8:0]         DVS_YEAR    = 9'd400;
    localparam logic [8:0]         DVS_MIN     = 9'd60;
    localparam logic [8:0]         DVS_HOUR    = 9'd24;
    // Reciprocals scaled by 2^23, 2^24 and 2^18, rounded up.
    localparam logic [18:0]        RECIP_YEAR  = 19'd20972;
    localparam logic [18:0]        RECIP_MIN   = 19'd279621;
    localparam logic [18:0]        RECIP_HOUR  = 19'd10923;

    logic signed [15:0] r_year;
    logic [3:0]         r_month;
    logic signed [11:0] r_day;
    logic [4:0]         r_hour;
    logic [5:0]         r_minute;
    logic signed [16:0] r_dmin;
    logic signed [10:0] r_dhour;
    logic signed [10:0] r_dday;
    logic signed [11:0] r_carry;
    logic [8:0]         r_m400;

    logic [17:0]        r_dvd;
    logic [11:0]        r_quo;

    logic [18:0]        s_recip;
    logic [36:0]        s_prod;
    logic [11:0]        s_quo;
    logic [17:0]        s_qd;
    logic [8:0]         s_rem;
    logic signed [18:0] s_min_sum;
    logic signed [13:0] s_hour_sum;

    logic [4:0]         s_len_cur;
    logic [4:0]         s_len_prev;
    logic [3:0]         s_prev_month;
    logic [8:0]         s_prev_m400;
    logic               s_fwd;
    logic               s_bwd;

    function automatic logic leap_of(input logic [8:0] m400);
        return (m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200)
            && (m400 != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // The quotient comes from a multiply by the scaled reciprocal, which is exact over
    // the dividend range of each quantity; the remainder follows in the next cycle.
    always_comb begin
        case (i_cmd.div_sel)
            dtoa_pkg::DIV_YEAR: s_recip = RECIP_YEAR;
            dtoa_pkg::DIV_MIN:  s_recip = RECIP_MIN;
            dtoa_pkg::DIV_HOUR: s_recip = RECIP_HOUR;
            default:            s_recip = '0;
        endcase
        s_prod = {19'd0, r_dvd} * {18'd0, s_recip};
        case (i_cmd.div_sel)
            dtoa_pkg::DIV_YEAR: begin
                s_quo = s_prod[34:23];
                s_qd  = {6'd0, r_quo} * {9'd0, DVS_YEAR};
            end
            dtoa_pkg::DIV_MIN: begin
                s_quo = s_prod[35:24];
                s_qd  = {6'd0, r_quo} * {9'd0, DVS_MIN};
            end
            dtoa_pkg::DIV_HOUR: begin
                s_quo = s_prod[29:18];
                s_qd  = {6'd0, r_quo} * {9'd0, DVS_HOUR};
            end
            default: begin
                s_quo = '0;
                s_qd  = '0;
            end
        endcase
        s_rem = 9'(r_dvd - s_qd);
    end

    always_comb begin
        s_min_sum  = $signed({13'd0, r_minute}) + 19'(r_dmin) + MIN_OFFSET;
        s_hour_sum = $signed({9'd0, r_hour}) + 14'(r_carry) + 14'(r_dhour) + HOUR_OFFSET;
    end

    // Month roll: forward when the day passes the month end, backward below day 1.
    always_comb begin
        s_len_cur    = month_len(r_month, leap_of(r_m400));
        s_prev_month = (r_month == 4'd1) ? 4'd12 : 4'(r_month - 4'd1);
        if (r_month == 4'd1) begin
            s_prev_m400 = (r_m400 == 9'd0) ? 9'd399 : 9'(r_m400 - 9'd1);
        end else begin
            s_prev_m400 = r_m400;
        end
        s_len_prev = month_len(s_prev_month, leap_of(s_prev_m400));
        s_fwd      = r_day > $signed({7'd0, s_len_cur});
        s_bwd      = r_day < 12'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year   <= $signed({2'b00, i_start_year});
            if (i_start_month == 4'd0) begin
                r_month <= 4'd1;
            end else if (i_start_month > 4'd12) begin
                r_month <= 4'd12;
            end else begin
                r_month <= i_start_month;
            end
            r_day    <= $signed({7'd0, i_start_day});
            r_hour   <= i_start_hour;
            r_minute <= i_start_minute;
            r_dmin   <= i_delta_minutes;
            r_dhour  <= i_delta_hours;
            r_dday   <= i_delta_days;
        end

        if (i_cmd.div_init) begin
            case (i_cmd.div_sel)
                dtoa_pkg::DIV_YEAR: begin
                    r_dvd <= {4'd0, r_year[13:0]};
                end
                dtoa_pkg::DIV_MIN: begin
                    r_dvd <= s_min_sum[17:0];
                end
                dtoa_pkg::DIV_HOUR: begin
                    r_dvd <= {4'd0, s_hour_sum};
                end
                default: begin
                    r_dvd <= '0;
                end
            endcase
        end

        if (i_cmd.div_step) begin
            r_quo <= s_quo;
        end

        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                dtoa_pkg::DIV_YEAR: begin
                    r_m400 <= s_rem;
                end
                dtoa_pkg::DIV_MIN: begin
                    r_minute <= s_rem[5:0];
                    r_carry  <= $signed(r_quo - MIN_BIAS);
                end
                dtoa_pkg::DIV_HOUR: begin
                    r_hour <= s_rem[4:0];
                    r_day  <= r_day + $signed(r_quo - HOUR_BIAS) + 12'(r_dday);
                end
                default: begin
                    r_m400 <= r_m400;
                end
            endcase
        end

        if (i_cmd.roll_step) begin
            if (s_fwd) begin
                r_day <= r_day - $signed({7'd0, s_len_cur});
                if (r_month == 4'd12) begin
                    r_month <= 4'd1;
                    r_year  <= r_year + 16'sd1;
                    r_m400  <= (r_m400 == 9'd399) ? 9'd0 : 9'(r_m400 + 9'd1);
                end else begin
                    r_month <= 4'(r_month + 4'd1);
                end
            end else if (s_bwd) begin
                r_day   <= r_day + $signed({7'd0, s_len_prev});
                r_month <= s_prev_month;
                r_m400  <= s_prev_m400;
                if (r_month == 4'd1) begin
                    r_year <= r_year - 16'sd1;
                end
            end
        end
    end

    assign o_sts.roll_done     = !s_fwd && !s_bwd;
    assign o_end_year          = r_year[13:0];
    assign o_end_month         = r_month;
    assign o_end_day           = r_day[4:0];
    assign o_end_hour          = r_hour;
    assign o_end_minute        = r_minute;
    assign o_year_out_of_range = r_year[15] | r_year[14];

endmodule

>>> rtl/dtoa_ctrl.sv
// Controller: sequences the three divisions and the month roll of one request.
module dtoa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dtoa_pkg::t_dp_sts i_sts,
    output dtoa_pkg::t_dp_cmd o_cmd,
    output logic              busy,
    output logic              o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_STEP,
        S_STORE,
        S_ROLL
    } t_state;

    t_state                                r_state;
    dtoa_pkg::t_div_sel                    r_sel;
    logic                                  r_busy;
    logic                                  r_valid;

    always_comb begin
        o_cmd.load      = start && !r_busy;
        o_cmd.div_init  = r_state == S_INIT;
        o_cmd.div_step  = r_state == S_STEP;
        o_cmd.div_store = r_state == S_STORE;
        o_cmd.div_sel   = r_sel;
        o_cmd.roll_step = r_state == S_ROLL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= dtoa_pkg::DIV_YEAR;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_INIT;
                        r_sel   <= dtoa_pkg::DIV_YEAR;
                        r_busy  <= 1'b1;
                    end
                end
                S_INIT: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    case (r_sel)
                        dtoa_pkg::DIV_YEAR: begin
                            r_sel   <= dtoa_pkg::DIV_MIN;
                            r_state <= S_INIT;
                        end
                        dtoa_pkg::DIV_MIN: begin
                            r_sel   <= dtoa_pkg::DIV_HOUR;
                            r_state <= S_INIT;
                        end
                        default: begin
                            r_state <= S_ROLL;
                        end
                    endcase
                end
                S_ROLL: begin
                    if (i_sts.roll_done) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;

endmodule

>>> rtl/dtoa_checker.sv
// Port-level checks of the date and time offset adder, bound to the top level.
`include "assert_macros.svh"

module dtoa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [3:0] o_end_month,
    input logic [4:0] o_end_day,
    input logic [4:0] o_end_hour,
    input logic [5:0] o_end_minute
);

    logic s_norm;

    assign s_norm = o_end_month >= 4'd1 && o_end_month <= 4'd12 && o_end_day >= 5'd1
        && o_end_hour <= 5'd23 && o_end_minute <= 6'd59;

    // An accepted request makes the block busy.
    `DTOA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // The result strobe lasts one cycle.
    `DTOA_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)

    // Busy drops exactly when the result is shown.
    `DTOA_ASSERT(a_busy_fall, i_clk, i_rst_n, $fell(busy) |-> o_valid)

    `DTOA_ASSERT(a_valid_idle, i_clk, i_rst_n, o_valid |-> !busy)

    // A delivered moment is always a normalized date and time.
    `DTOA_ASSERT(a_result_norm, i_clk, i_rst_n, o_valid |-> s_norm)

endmodule

bind date_time_offset_adder_core dtoa_checker u_dtoa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_end_month  (o_end_month),
    .o_end_day    (o_end_day),
    .o_end_hour   (o_end_hour),
    .o_end_minute (o_end_minute)
);

>>> tb/tb_date_time_offset_adder_core.sv
// Self-checking testbench for the date and time offset adder, with directed and random requests.
module tb_date_time_offset_adder_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [16:0] delta_minutes;
        logic [10:0] delta_hours;
        logic [10:0] delta_days;
    } t_date_request;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        year_out_of_range;
    } t_date_result;

    typedef struct packed {
        t_date_request req;
        logic          typed;
        t_date_result  want;
    } t_directed_row;

    localparam int RANDOM_REQUESTS = 1830;
    localparam int SETTLE_CYCLES   = 100;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [13:0]        i_start_year;
    logic [3:0]         i_start_month;
    logic [4:0]         i_start_day;
    logic [4:0]         i_start_hour;
    logic [5:0]         i_start_minute;
    logic signed [16:0] i_delta_minutes;
    logic signed [10:0] i_delta_hours;
    logic signed [10:0] i_delta_days;
    logic               o_valid;
    logic [13:0]        o_end_year;
    logic [3:0]         o_end_month;
    logic [4:0]         o_end_day;
    logic [4:0]         o_end_hour;
    logic [5:0]         o_end_minute;
    logic               o_year_out_of_range;

    t_date_result  pending_results[$];
    t_directed_row directed_rows[$];
    t_date_result  oldest_result;
    int            mismatch_count = 0;
    int            burst_left = 0;

    date_time_offset_adder_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_start_year       (i_start_year),
        .i_start_month      (i_start_month),
        .i_start_day        (i_start_day),
        .i_start_hour       (i_start_hour),
        .i_start_minute     (i_start_minute),
        .i_delta_minutes    (i_delta_minutes),
        .i_delta_hours      (i_delta_hours),
        .i_delta_days       (i_delta_days),
        .o_valid            (o_valid),
        .o_end_year         (o_end_year),
        .o_end_month        (o_end_month),
        .o_end_day          (o_end_day),
        .o_end_hour         (o_end_hour),
        .o_end_minute       (o_end_minute),
        .o_year_out_of_range(o_year_out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("timeout: results still outstanding");
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want_val);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want_val);
    endtask

    function automatic bit leap_year(input int year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int month_days(input int month, input int year);
        case (month) inside
            2:           return leap_year(year) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Quotient rounded toward minus infinity, for a positive divisor.
    function automatic int floor_quot(input int n, input int d);
        int q;
        q = n / d;
        if (n - q * d < 0) q--;
        return q;
    endfunction

    function automatic t_date_result add_offset(input t_date_request req);
        int year, month, day, hour, minute, sum, carry, len;
        t_date_result res;
        year   = req.year;
        month  = req.month;
        day    = req.day;
        hour   = req.hour;
        minute = req.minute;
        if (month < 1) month = 1;
        if (month > 12) month = 12;

        sum    = minute + int'($signed(req.delta_minutes));
        carry  = floor_quot(sum, 60);
        minute = sum - carry * 60;
        sum    = hour + carry + int'($signed(req.delta_hours));
        carry  = floor_quot(sum, 24);
        hour   = sum - carry * 24;
        day    = day + carry + int'($signed(req.delta_days));

        len = month_days(month, year);
        while (day > len) begin
            day -= len;
            month++;
            if (month > 12) begin
                month = 1;
                year++;
            end
            len = month_days(month, year);
        end
        while (day < 1) begin
            month--;
            if (month < 1) begin
                month = 12;
                year--;
            end
            day += month_days(month, year);
        end

        res.year              = year[13:0];
        res.month             = month[3:0];
        res.day               = day[4:0];
        res.hour              = hour[4:0];
        res.minute            = minute[5:0];
        res.year_out_of_range = (year < 0) || (year > 16383);
        return res;
    endfunction

    function automatic t_date_request moment(input int year, input int month, input int day,
                                             input int hour, input int minute, input int dmin,
                                             input int dhour, input int dday);
        t_date_request req;
        req.year          = year[13:0];
        req.month         = month[3:0];
        req.day           = day[4:0];
        req.hour          = hour[4:0];
        req.minute        = minute[5:0];
        req.delta_minutes = dmin[16:0];
        req.delta_hours   = dhour[10:0];
        req.delta_days    = dday[10:0];
        return req;
    endfunction

    function automatic t_date_result outcome(input int year, input int month, input int day,
                                             input int hour, input int minute, input bit oor);
        t_date_result res;
        res.year              = year[13:0];
        res.month             = month[3:0];
        res.day               = day[4:0];
        res.hour              = hour[4:0];
        res.minute            = minute[5:0];
        res.year_out_of_range = oor;
        return res;
    endfunction

    task automatic add_row(input t_date_request req, input bit typed, input t_date_result want);
        directed_rows.push_back({req, typed, want});
    endtask

    // Mostly small offsets, with the field extremes and full-range values mixed in.
    function automatic int random_delta(input int width);
        int top;
        top = 1 << (width - 1);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return int'($urandom_range(0, 6)) - 3;
            2:       return $urandom_range(0, 1) ? top - 1 : -top;
            3:       return int'($urandom_range(0, 2 * top - 1)) - top;
            default: return int'($urandom_range(0, top / 8)) - top / 16;
        endcase
    endfunction

    function automatic t_date_request random_request();
        int year, month, day, hour, minute;
        case ($urandom_range(0, 9))
            0:       year = $urandom_range(0, 3);
            1:       year = $urandom_range(16380, 16383);
            2:       year = 100 * $urandom_range(0, 163);
            default: year = $urandom_range(0, 16383);
        endcase
        if ($urandom_range(0, 4) != 0) begin
            month  = $urandom_range(1, 12);
            day    = $urandom_range(1, month_days(month, year));
            hour   = $urandom_range(0, 23);
            minute = $urandom_range(0, 59);
        end else begin
            // Out-of-range codes that the block folds.
            month  = $urandom_range(0, 15);
            day    = $urandom_range(0, 31);
            hour   = $urandom_range(0, 31);
            minute = $urandom_range(0, 63);
        end
        return moment(year, month, day, hour, minute,
                      random_delta(17), random_delta(11), random_delta(11));
    endfunction

    // Random pause before the next request, with occasional back-to-back bursts.
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Called at a falling edge; returns at the falling edge after the gap that follows.
    task automatic send_request(input t_date_request req, input t_date_result want);
        int gap;
        start           = 1'b1;
        i_start_year    = req.year;
        i_start_month   = req.month;
        i_start_day     = req.day;
        i_start_hour    = req.hour;
        i_start_minute  = req.minute;
        i_delta_minutes = req.delta_minutes;
        i_delta_hours   = req.delta_hours;
        i_delta_days    = req.delta_days;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(want);
        gap = next_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending, end_year", o_end_year, 0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_end_year !== oldest_result.year)
                    report_mismatch("end_year", o_end_year, oldest_result.year);
                if (o_end_month !== oldest_result.month)
                    report_mismatch("end_month", o_end_month, oldest_result.month);
                if (o_end_day !== oldest_result.day)
                    report_mismatch("end_day", o_end_day, oldest_result.day);
                if (o_end_hour !== oldest_result.hour)
                    report_mismatch("end_hour", o_end_hour, oldest_result.hour);
                if (o_end_minute !== oldest_result.minute)
                    report_mismatch("end_minute", o_end_minute, oldest_result.minute);
                if (o_year_out_of_range !== oldest_result.year_out_of_range)
                    report_mismatch("year_out_of_range", o_year_out_of_range,
                                    oldest_result.year_out_of_range);
            end
        end
    end

    initial begin
        t_date_request req;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_start_year    = '0;
        i_start_month   = '0;
        i_start_day     = '0;
        i_start_hour    = '0;
        i_start_minute  = '0;
        i_delta_minutes = '0;
        i_delta_hours   = '0;
        i_delta_days    = '0;

        // Leap-year borders, year overflow both ways, folded codes, field extremes.
        add_row(moment(2024, 2, 28, 23, 59, 1, 0, 0), 1, outcome(2024, 2, 29, 0, 0, 0));
        add_row(moment(2023, 2, 28, 23, 59, 1, 0, 0), 1, outcome(2023, 3, 1, 0, 0, 0));
        add_row(moment(1900, 2, 28, 12, 0, 0, 0, 1), 1, outcome(1900, 3, 1, 12, 0, 0));
        add_row(moment(2000, 2, 28, 12, 0, 0, 0, 1), 1, outcome(2000, 2, 29, 12, 0, 0));
        add_row(moment(2100, 2, 28, 0, 0, 1440, 0, 0), 1, outcome(2100, 3, 1, 0, 0, 0));
        add_row(moment(2400, 2, 28, 0, 0, 0, 24, 0), 1, outcome(2400, 2, 29, 0, 0, 0));
        add_row(moment(1999, 12, 31, 23, 59, 60, 0, 0), 1, outcome(2000, 1, 1, 0, 59, 0));
        add_row(moment(16383, 12, 31, 23, 59, 1, 0, 0), 1, outcome(0, 1, 1, 0, 0, 1));
        add_row(moment(0, 1, 1, 0, 0, -1, 0, 0), 1, outcome(16383, 12, 31, 23, 59, 1));
        add_row(moment(2024, 6, 15, 12, 30, 0, 0, 0), 1, outcome(2024, 6, 15, 12, 30, 0));
        add_row(moment(2024, 0, 15, 8, 0, 0, 0, 0), 1, outcome(2024, 1, 15, 8, 0, 0));
        add_row(moment(2024, 15, 31, 8, 0, 0, 0, 0), 1, outcome(2024, 12, 31, 8, 0, 0));
        add_row(moment(2024, 13, 1, 0, 0, 0, 0, 0), 1, outcome(2024, 12, 1, 0, 0, 0));
        add_row(moment(2024, 3, 1, 0, 0, 0, 0, -1), 1, outcome(2024, 2, 29, 0, 0, 0));
        add_row(moment(2023, 3, 0, 0, 0, 0, 0, 0), 1, outcome(2023, 2, 28, 0, 0, 0));
        add_row(moment(2023, 2, 31, 0, 0, 0, 0, 0), 1, outcome(2023, 3, 3, 0, 0, 0));
        add_row(moment(16383, 0, 0, 0, 0, 0, 0, 0), 1, outcome(16382, 12, 31, 0, 0, 0));
        add_row(moment(2024, 1, 1, 0, 0, 65535, 1023, 1023), 0, '0);
        add_row(moment(2024, 12, 31, 23, 59, -65536, -1024, -1024), 0, '0);
        add_row(moment(2023, 12, 31, 31, 63, 0, 0, 0), 0, '0);
        add_row(moment(16383, 12, 31, 23, 59, 65535, 1023, 1023), 0, '0);
        add_row(moment(0, 1, 1, 0, 0, -65536, -1024, -1024), 0, '0);
        add_row(moment(16383, 15, 31, 31, 63, -1, -1, -1), 0, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            req = directed_rows[i].req;
            send_request(req, directed_rows[i].typed ? directed_rows[i].want
                                                     : add_offset(req));
        end
        repeat (RANDOM_REQUESTS) begin
            req = random_request();
            send_request(req, add_offset(req));
        end
        start = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
